// ----- rtl/core/simplex_noise_2d_top_macros.svh -----
// ----------------------------------------------------------------------------
// simplex_noise_2d_top_macros.svh
// Assertion macros shared by the simplex noise RTL.
// ----------------------------------------------------------------------------
`ifndef SIMPLEX_NOISE_2D_TOP_MACROS_SVH
`define SIMPLEX_NOISE_2D_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SNX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SNX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/snx_pkg.sv -----
// ----------------------------------------------------------------------------
// snx_pkg
// Constants, widths and small functions for the simplex noise pipeline.
// ----------------------------------------------------------------------------
package snx_pkg;

    // table geometry
    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int PERM_W     = 8;
    localparam int GSEL_W     = 4;

    // number formats
    localparam int COORD_W = 32;
    localparam int IJ_W    = 18;   // cell index
    localparam int T_W     = 35;   // unskew offset
    localparam int D_W     = 20;   // corner offsets, Q16 with small integer part
    localparam int G_W     = 18;   // gradient components
    localparam int C_W     = 32;   // one corner contribution
    localparam int NOISE_W = 16;

    // pipeline depth, stage 0 captures the item, last stage is the output
    localparam int NSTAGE = 14;

    // skew constants, Q30
    localparam logic signed [29:0] F2_Q30 = 30'sd393016785;
    localparam logic signed [29:0] G2_Q30 = 30'sd226908346;

    // Q16 constants
    localparam logic signed [D_W-1:0] Q_ONE_D = 20'sd65536;
    localparam logic signed [D_W-1:0] Q_G2_D  = 20'sd13849;
    localparam logic signed [G_W-1:0] G_ONE   = 18'sd65536;
    localparam logic signed [G_W-1:0] G_HALF  = 18'sd32768;
    localparam logic signed [G_W-1:0] G_SQ    = 18'sd56756;
    localparam logic signed [G_W-1:0] G_ZERO  = 18'sd0;

    // output scale 45.23 in Q15
    localparam logic signed [21:0] SCALE_Q15 = 22'sd1482097;

    typedef logic [NSTAGE-1:0] stage_en_t;

    // byte mod 12 by reciprocal multiply, exact for 0..255
    function automatic logic [GSEL_W-1:0] mod12(input logic [PERM_W-1:0] v);
        logic [15:0] p;
        logic [4:0]  q;
        logic [7:0]  r;
        p = {8'd0, v} * 16'd171;
        q = p[15:11];
        r = v - 8'({q, 3'b000}) - 8'({q, 2'b00});
        return r[GSEL_W-1:0];
    endfunction

    // twelve unit gradients at 30 degree steps, x component
    function automatic logic signed [G_W-1:0] grad_x(input logic [GSEL_W-1:0] g);
        logic signed [G_W-1:0] r;
        case (g)
            4'd0:    r = G_ONE;
            4'd1:    r = G_SQ;
            4'd2:    r = G_HALF;
            4'd3:    r = G_ZERO;
            4'd4:    r = -G_HALF;
            4'd5:    r = -G_SQ;
            4'd6:    r = -G_ONE;
            4'd7:    r = -G_SQ;
            4'd8:    r = -G_HALF;
            4'd9:    r = G_ZERO;
            4'd10:   r = G_HALF;
            4'd11:   r = G_SQ;
            default: r = G_ZERO;
        endcase
        return r;
    endfunction

    // y component
    function automatic logic signed [G_W-1:0] grad_y(input logic [GSEL_W-1:0] g);
        logic signed [G_W-1:0] r;
        case (g)
            4'd0:    r = G_ZERO;
            4'd1:    r = G_HALF;
            4'd2:    r = G_SQ;
            4'd3:    r = G_ONE;
            4'd4:    r = G_SQ;
            4'd5:    r = G_HALF;
            4'd6:    r = G_ZERO;
            4'd7:    r = -G_HALF;
            4'd8:    r = -G_SQ;
            4'd9:    r = -G_ONE;
            4'd10:   r = -G_SQ;
            4'd11:   r = -G_HALF;
            default: r = G_ZERO;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/simplex_noise_2d_top.sv -----
// ----------------------------------------------------------------------------
// simplex_noise_2d_top
// Two-dimensional simplex noise, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries mode, x_coord, y_coord,
//   table_index and table_value. Mode 1 loads one permutation byte (and its
//   gradient index, byte mod 12); mode 0 evaluates noise at the Q16.16 point.
//   Output channel out_valid/out_stall carries noise, Q1.15, saturated.
//   Load the whole table before the first evaluation.
//   Throughput: one item per cycle while out_stall is low; the pipeline has
//   14 register stages, and an evaluation shows on noise once it reaches
//   the last of them. A load gives no output item.
//   The permutation table is read two ports per cycle (two RAM copies) and
//   the gradient table three (three copies); loads write every copy in the
//   same pipeline slot as the reads, so loads and evaluations keep order.
//   Reset clears all valid bits; table contents are kept and hold no
//   defined value until loaded. A stalled output holds its item; stages
//   behind it fill up, then in_stall rises.
// ----------------------------------------------------------------------------
`include "simplex_noise_2d_top_macros.svh"

module simplex_noise_2d_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  mode,
    input  logic signed [snx_pkg::COORD_W-1:0]    x_coord,
    input  logic signed [snx_pkg::COORD_W-1:0]    y_coord,
    input  logic [7:0]                            table_index,
    input  logic [7:0]                            table_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [snx_pkg::NOISE_W-1:0]    noise
);
    import snx_pkg::*;

    stage_en_t              en;
    logic [NSTAGE-1:0]      v_reg, v_next;
    logic [NSTAGE-2:0]      ld_reg;

    // load item payload, travels to the grad write slot
    logic [IDX_W-1:0]       idx_reg [5];
    logic [PERM_W-1:0]      val_reg [3];
    logic [GSEL_W-1:0]      gs_reg [5];

    logic signed [IJ_W-1:0] j_s2, i_s4;
    logic signed [D_W-1:0]  x0_s4, y0_s4;
    logic [IDX_W-1:0]       pj_addr, pj1_addr;
    logic [PERM_W-1:0]      pj_rd, pj1_rd;
    logic [PERM_W-1:0]      pj4_reg, pj14_reg;
    logic                   perm_we, grad_we;
    logic                   lower;
    logic [IDX_W-1:0]       ga0, ga1, ga2, i_lo;
    logic [GSEL_W-1:0]      g0_rd, g1_rd, g2_rd;
    logic signed [D_W-1:0]  dx_reg [3];
    logic signed [D_W-1:0]  dy_reg [3];
    logic signed [C_W-1:0]  c0, c1, c2;
    logic signed [C_W+1:0]  sum_reg;
    logic signed [C_W+23:0] prod_reg;
    logic signed [C_W+23:0] rnd;
    logic signed [23:0]     r_full;
    logic signed [NOISE_W-1:0] noise_reg, noise_next;

    // stage enables: a stage loads when empty or when its successor moves
    always_comb
    begin
        en[NSTAGE-1] = !v_reg[NSTAGE-1] || !out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_stall = !en[0];

    // valid chain; loads drop out before the output stage
    always_comb
    begin
        v_next[0] = in_valid;
        for (int k = 1; k < NSTAGE - 1; k++)
        begin
            v_next[k] = v_reg[k-1];
        end
        v_next[NSTAGE-1] = v_reg[NSTAGE-2] && !ld_reg[NSTAGE-2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    // load flag and load payload
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ld_reg[0]  <= mode;
            idx_reg[0] <= table_index[IDX_W-1:0];
            val_reg[0] <= table_value;
            gs_reg[0]  <= mod12(table_value);
        end
        for (int k = 1; k < NSTAGE - 1; k++)
        begin
            if (en[k])
            begin
                ld_reg[k] <= ld_reg[k-1];
            end
        end
        for (int k = 1; k < 5; k++)
        begin
            if (en[k])
            begin
                idx_reg[k] <= idx_reg[k-1];
                gs_reg[k]  <= gs_reg[k-1];
            end
        end
        for (int k = 1; k < 3; k++)
        begin
            if (en[k])
            begin
                val_reg[k] <= val_reg[k-1];
            end
        end
    end

    // skew and cell origin, stages 0 to 4
    snx_front u_front (
        .clk     (clk),
        .en      (en),
        .x_coord (x_coord),
        .y_coord (y_coord),
        .j_s2    (j_s2),
        .i_s4    (i_s4),
        .x0_s4   (x0_s4),
        .y0_s4   (y0_s4)
    );

    // permutation reads at j and j+1, written by a load in the same slot
    assign pj_addr  = j_s2[IDX_W-1:0];
    assign pj1_addr = j_s2[IDX_W-1:0] + IDX_W'(1);
    assign perm_we  = en[3] && v_reg[2] && ld_reg[2];

    snx_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm0 (
        .clk (clk), .we (perm_we), .waddr (idx_reg[2]), .wdata (val_reg[2]),
        .re (en[3]), .raddr (pj_addr), .rdata (pj_rd)
    );

    snx_ram #(.WIDTH(PERM_W), .DEPTH(TABLE_SIZE)) u_perm1 (
        .clk (clk), .we (perm_we), .waddr (idx_reg[2]), .wdata (val_reg[2]),
        .re (en[3]), .raddr (pj1_addr), .rdata (pj1_rd)
    );

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            pj4_reg  <= pj_rd;
            pj14_reg <= pj1_rd;
        end
    end

    // triangle choice and gradient addresses
    assign lower = (x0_s4 > y0_s4);
    assign i_lo  = i_s4[IDX_W-1:0];
    assign ga0   = i_lo + pj4_reg;
    assign ga2   = i_lo + IDX_W'(1) + pj14_reg;
    assign ga1   = lower ? (i_lo + IDX_W'(1) + pj4_reg) : (i_lo + pj14_reg);
    assign grad_we = en[5] && v_reg[4] && ld_reg[4];

    snx_ram #(.WIDTH(GSEL_W), .DEPTH(TABLE_SIZE)) u_grad0 (
        .clk (clk), .we (grad_we), .waddr (idx_reg[4]), .wdata (gs_reg[4]),
        .re (en[5]), .raddr (ga0), .rdata (g0_rd)
    );

    snx_ram #(.WIDTH(GSEL_W), .DEPTH(TABLE_SIZE)) u_grad1 (
        .clk (clk), .we (grad_we), .waddr (idx_reg[4]), .wdata (gs_reg[4]),
        .re (en[5]), .raddr (ga1), .rdata (g1_rd)
    );

    snx_ram #(.WIDTH(GSEL_W), .DEPTH(TABLE_SIZE)) u_grad2 (
        .clk (clk), .we (grad_we), .waddr (idx_reg[4]), .wdata (gs_reg[4]),
        .re (en[5]), .raddr (ga2), .rdata (g2_rd)
    );

    // corner offsets, stage 5
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            dx_reg[0] <= x0_s4;
            dy_reg[0] <= y0_s4;
            dx_reg[1] <= x0_s4 - (lower ? Q_ONE_D : '0) + Q_G2_D;
            dy_reg[1] <= y0_s4 - (lower ? '0 : Q_ONE_D) + Q_G2_D;
            dx_reg[2] <= x0_s4 - Q_ONE_D + Q_G2_D + Q_G2_D;
            dy_reg[2] <= y0_s4 - Q_ONE_D + Q_G2_D + Q_G2_D;
        end
    end

    // three corner pipes, stages 6 to 10
    snx_corner u_corner0 (
        .clk (clk), .en (en[10:6]), .dx (dx_reg[0]), .dy (dy_reg[0]),
        .gsel (g0_rd), .contrib (c0)
    );

    snx_corner u_corner1 (
        .clk (clk), .en (en[10:6]), .dx (dx_reg[1]), .dy (dy_reg[1]),
        .gsel (g1_rd), .contrib (c1)
    );

    snx_corner u_corner2 (
        .clk (clk), .en (en[10:6]), .dx (dx_reg[2]), .dy (dy_reg[2]),
        .gsel (g2_rd), .contrib (c2)
    );

    // scale by 45.23, round half up to Q1.15, saturate
    assign rnd    = prod_reg + (C_W+24)'(64'sd2147483648);
    assign r_full = rnd[C_W+23:32];

    always_comb
    begin
        if (r_full > 24'sd32767)
        begin
            noise_next = 16'sh7fff;
        end
        else if (r_full < -24'sd32768)
        begin
            noise_next = 16'sh8000;
        end
        else
        begin
            noise_next = r_full[NOISE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[11])
        begin
            sum_reg <= (C_W+2)'(c0) + (C_W+2)'(c1) + (C_W+2)'(c2);
        end
        if (en[12])
        begin
            prod_reg <= sum_reg * SCALE_Q15;
        end
        if (en[13])
        begin
            noise_reg <= noise_next;
        end
    end

    assign out_valid = v_reg[NSTAGE-1];
    assign noise     = noise_reg;

    // input backs up only behind a full, stalled pipe
    `SNX_ASSERT_IMP(a_stall_full, in_stall, out_valid && out_stall, "in_stall without backlog")
    // a load leaving the last inner stage never becomes an output item
    `SNX_ASSERT_NXT(a_load_drop, v_reg[NSTAGE-2] && ld_reg[NSTAGE-2] && en[NSTAGE-1], !out_valid, "load item reached the output")
    // an evaluation moving to the output stage is shown next cycle
    `SNX_ASSERT_NXT(a_eval_out, v_reg[NSTAGE-2] && !ld_reg[NSTAGE-2] && en[NSTAGE-1], out_valid, "evaluation item lost")

endmodule

// ----- rtl/core/snx_ram.sv -----
// ----------------------------------------------------------------------------
// snx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module snx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/snx_front.sv -----
// ----------------------------------------------------------------------------
// snx_front
// Skew to the simplex cell, unskew offset and first corner offset.
// Stages 0 to 4 of the pipeline.
// ----------------------------------------------------------------------------
module snx_front (
    input  logic                                   clk,
    input  snx_pkg::stage_en_t                     en,
    input  logic signed [snx_pkg::COORD_W-1:0]     x_coord,
    input  logic signed [snx_pkg::COORD_W-1:0]     y_coord,
    output logic signed [snx_pkg::IJ_W-1:0]        j_s2,
    output logic signed [snx_pkg::IJ_W-1:0]        i_s4,
    output logic signed [snx_pkg::D_W-1:0]         x0_s4,
    output logic signed [snx_pkg::D_W-1:0]         y0_s4
);
    import snx_pkg::*;

    logic signed [COORD_W-1:0] x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [COORD_W-1:0] x3_reg, y3_reg;
    logic signed [62:0]        s1_reg;
    logic signed [62:0]        s1_next;
    logic signed [COORD_W:0]   xy_sum;
    logic signed [63:0]        ax_sum, ay_sum;
    logic signed [IJ_W-1:0]    i2_reg, j2_reg, i3_reg, j3_reg, i4_reg;
    logic signed [IJ_W:0]      ij_sum;
    logic signed [48:0]        t_prod;
    logic signed [T_W-1:0]     t3_reg, t3_next;
    logic signed [35:0]        x0_wide, y0_wide;
    logic signed [D_W-1:0]     x4_reg, y4_reg;

    // stage 1: s = (x + y) * F2
    assign xy_sum  = {x0_reg[COORD_W-1], x0_reg} + {y0_reg[COORD_W-1], y0_reg};
    assign s1_next = xy_sum * F2_Q30;

    // stage 2: cell index, floor of (x + s) in Q46
    assign ax_sum = {{2{x1_reg[COORD_W-1]}}, x1_reg, 30'd0} + {s1_reg[62], s1_reg};
    assign ay_sum = {{2{y1_reg[COORD_W-1]}}, y1_reg, 30'd0} + {s1_reg[62], s1_reg};

    // stage 3: unskew offset, rounded half up to Q16
    assign ij_sum  = {i2_reg[IJ_W-1], i2_reg} + {j2_reg[IJ_W-1], j2_reg};
    assign t_prod  = ij_sum * G2_Q30 + 49'sd8192;
    assign t3_next = t_prod[48:14];

    // stage 4: distance to the cell origin
    assign x0_wide = {{4{x3_reg[COORD_W-1]}}, x3_reg}
                   - {{2{i3_reg[IJ_W-1]}}, i3_reg, 16'd0}
                   + {t3_reg[T_W-1], t3_reg};
    assign y0_wide = {{4{y3_reg[COORD_W-1]}}, y3_reg}
                   - {{2{j3_reg[IJ_W-1]}}, j3_reg, 16'd0}
                   + {t3_reg[T_W-1], t3_reg};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x0_reg <= x_coord;
            y0_reg <= y_coord;
        end
        if (en[1])
        begin
            s1_reg <= s1_next;
            x1_reg <= x0_reg;
            y1_reg <= y0_reg;
        end
        if (en[2])
        begin
            i2_reg <= ax_sum[63:46];
            j2_reg <= ay_sum[63:46];
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
        end
        if (en[3])
        begin
            t3_reg <= t3_next;
            i3_reg <= i2_reg;
            j3_reg <= j2_reg;
            x3_reg <= x2_reg;
            y3_reg <= y2_reg;
        end
        if (en[4])
        begin
            i4_reg <= i3_reg;
            x4_reg <= x0_wide[D_W-1:0];
            y4_reg <= y0_wide[D_W-1:0];
        end
    end

    assign j_s2  = j2_reg;
    assign i_s4  = i4_reg;
    assign x0_s4 = x4_reg;
    assign y0_s4 = y4_reg;

endmodule

// ----- rtl/core/snx_corner.sv -----
// ----------------------------------------------------------------------------
// snx_corner
// Falloff contribution of one simplex corner, (0.5 - d^2)^4 * dot(g, d).
// Stages 6 to 10 of the pipeline.
// ----------------------------------------------------------------------------
module snx_corner (
    input  logic                                 clk,
    input  logic [4:0]                           en,
    input  logic signed [snx_pkg::D_W-1:0]       dx,
    input  logic signed [snx_pkg::D_W-1:0]       dy,
    input  logic [snx_pkg::GSEL_W-1:0]           gsel,
    output logic signed [snx_pkg::C_W-1:0]       contrib
);
    import snx_pkg::*;

    logic signed [2*D_W-1:0]     sqx_reg, sqy_reg;
    logic signed [G_W+D_W-1:0]   gdx_reg, gdy_reg;
    logic signed [2*D_W:0]       r2_sum;
    logic [24:0]                 r2;
    logic [16:0]                 t_diff;
    logic signed [G_W+D_W:0]     dot_sum;
    logic [15:0]                 t_reg;
    logic [31:0]                 t_sq;
    logic [14:0]                 t2_reg;
    logic [29:0]                 t2_sq;
    logic [12:0]                 t4_reg;
    logic signed [17:0]          dot7_reg, dot8_reg, dot9_reg;
    logic                        cut7_reg, cut8_reg, cut9_reg;
    logic signed [C_W-1:0]       c_prod;
    logic signed [C_W-1:0]       c_reg, c_next;

    // stage 7: r2 = d.d floored to Q16, t = 0.5 - r2, dot floored to Q16
    assign r2_sum  = {sqx_reg[2*D_W-1], sqx_reg} + {sqy_reg[2*D_W-1], sqy_reg};
    assign r2      = r2_sum[40:16];
    assign t_diff  = 17'd32768 - {1'b0, r2[15:0]};
    assign dot_sum = {gdx_reg[G_W+D_W-1], gdx_reg} + {gdy_reg[G_W+D_W-1], gdy_reg};

    // stages 8 and 9: squares floored to Q16
    assign t_sq  = t_reg * t_reg;
    assign t2_sq = t2_reg * t2_reg;

    // stage 10: corner past the cutoff adds nothing
    assign c_prod = $signed({1'b0, t4_reg}) * dot9_reg;
    assign c_next = cut9_reg ? '0 : c_prod;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sqx_reg <= dx * dx;
            sqy_reg <= dy * dy;
            gdx_reg <= grad_x(gsel) * dx;
            gdy_reg <= grad_y(gsel) * dy;
        end
        if (en[1])
        begin
            t_reg    <= t_diff[15:0];
            cut7_reg <= (r2 > 25'd32768);
            dot7_reg <= dot_sum[33:16];
        end
        if (en[2])
        begin
            t2_reg   <= t_sq[30:16];
            cut8_reg <= cut7_reg;
            dot8_reg <= dot7_reg;
        end
        if (en[3])
        begin
            t4_reg   <= t2_sq[28:16];
            cut9_reg <= cut8_reg;
            dot9_reg <= dot8_reg;
        end
        if (en[4])
        begin
            c_reg <= c_next;
        end
    end

    assign contrib = c_reg;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for simplex_noise_2d_top. Loads the permutation table,
// drives directed and random points and table reloads with random gaps on
// both channels, and checks every noise item against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam logic MODE_EVAL = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    localparam longint F2_Q30    = 64'sd393016785;
    localparam longint G2_Q30    = 64'sd226908346;
    localparam longint RND_Q30   = 64'sd8192;
    localparam longint ONE_Q16   = 64'sd65536;
    localparam longint HALF_Q16  = 64'sd32768;
    localparam longint SQ3H_Q16  = 64'sd56756;
    localparam longint G2_Q16    = 64'sd13849;
    localparam longint GAIN_Q15  = 64'sd1482097;
    localparam int     CYCLE_CAP = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic signed [snx_pkg::COORD_W-1:0] x_coord;
    logic signed [snx_pkg::COORD_W-1:0] y_coord;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic        out_valid;
    logic        out_stall;
    logic signed [snx_pkg::NOISE_W-1:0] noise;

    // shadow copy of the tables
    logic [7:0]  perm_shadow [256];
    logic [3:0]  gsel_shadow [256];

    logic signed [15:0] noise_expected_q [$];
    bit          failed;
    bit          no_idle;
    int          cycle_count;

    simplex_noise_2d_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .table_index (table_index),
        .table_value (table_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise       (noise)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // contribution of one corner, Q32
    function automatic longint corner_term(longint dx, longint dy, logic [3:0] g);
        longint gx, gy, r2, t, t2, t4, dot;
        case (g)
            4'd0:    begin gx = ONE_Q16;   gy = 0;          end
            4'd1:    begin gx = SQ3H_Q16;  gy = HALF_Q16;   end
            4'd2:    begin gx = HALF_Q16;  gy = SQ3H_Q16;   end
            4'd3:    begin gx = 0;         gy = ONE_Q16;    end
            4'd4:    begin gx = -HALF_Q16; gy = SQ3H_Q16;   end
            4'd5:    begin gx = -SQ3H_Q16; gy = HALF_Q16;   end
            4'd6:    begin gx = -ONE_Q16;  gy = 0;          end
            4'd7:    begin gx = -SQ3H_Q16; gy = -HALF_Q16;  end
            4'd8:    begin gx = -HALF_Q16; gy = -SQ3H_Q16;  end
            4'd9:    begin gx = 0;         gy = -ONE_Q16;   end
            4'd10:   begin gx = HALF_Q16;  gy = -SQ3H_Q16;  end
            default: begin gx = SQ3H_Q16;  gy = -HALF_Q16;  end
        endcase
        r2 = (dx * dx + dy * dy) >>> 16;
        t  = HALF_Q16 - r2;
        if (t < 0)
            return 0;
        t2  = (t * t) >>> 16;
        t4  = (t2 * t2) >>> 16;
        dot = (gx * dx + gy * dy) >>> 16;
        return t4 * dot;
    endfunction

    // gradient index for cell corner (a, b), indices wrap at 256
    function automatic logic [3:0] corner_grad(longint a, longint b);
        longint p;
        p = longint'(perm_shadow[b & 255]);
        return gsel_shadow[(a + p) & 255];
    endfunction

    function automatic logic signed [15:0] predict_noise(longint x, longint y);
        longint s, ci, cj, t, x0, y0, x1, y1, x2, y2, i1, j1, sum, r;
        s  = (x + y) * F2_Q30;
        ci = (x * (longint'(1) << 30) + s) >>> 46;
        cj = (y * (longint'(1) << 30) + s) >>> 46;
        t  = ((ci + cj) * G2_Q30 + RND_Q30) >>> 14;
        x0 = x - ci * ONE_Q16 + t;
        y0 = y - cj * ONE_Q16 + t;
        // lower or upper triangle
        if (x0 > y0)
        begin
            i1 = 1; j1 = 0;
        end
        else
        begin
            i1 = 0; j1 = 1;
        end
        x1 = x0 - i1 * ONE_Q16 + G2_Q16;
        y1 = y0 - j1 * ONE_Q16 + G2_Q16;
        x2 = x0 - ONE_Q16 + 2 * G2_Q16;
        y2 = y0 - ONE_Q16 + 2 * G2_Q16;
        sum = corner_term(x0, y0, corner_grad(ci, cj))
            + corner_term(x1, y1, corner_grad(ci + i1, cj + j1))
            + corner_term(x2, y2, corner_grad(ci + 1, cj + 1));
        r = (sum * GAIN_Q15 + (longint'(1) << 31)) >>> 32;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    // send one item after a random gap, predict on acceptance
    task automatic send_item(logic m, logic [31:0] xv, logic [31:0] yv,
                             logic [7:0] idx, logic [7:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        x_coord     <= xv;
        y_coord     <= yv;
        table_index <= idx;
        table_value <= val;
        do
            @(posedge clk);
        while (in_stall);
        if (m == MODE_LOAD)
        begin
            perm_shadow[idx] = val;
            gsel_shadow[idx] = 4'(val % 8'd12);
        end
        else
            noise_expected_q.push_back(predict_noise(longint'($signed(xv)),
                                                     longint'($signed(yv))));
    endtask

    task automatic send_point(logic [31:0] xv, logic [31:0] yv);
        send_item(MODE_EVAL, xv, yv, 8'($urandom), 8'($urandom));
    endtask

    // fill every table entry, x/y carry junk that must be ignored
    task automatic test_table_load();
        for (int n = 0; n < 256; n++)
            send_item(MODE_LOAD, $urandom, $urandom, 8'(n), 8'($urandom));
    endtask

    // extremes, diagonal, cell edges, wrap
    task automatic test_directed_points();
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h0001_8000, 32'h0001_8000);
        send_point(32'h0000_8000, 32'h0000_7FFF);
        send_point(32'h0000_7FFF, 32'h0000_8000);
        send_point(32'h0001_0000, 32'h0000_0000);
        send_point(32'hFFFF_0000, 32'h0000_FFFF);
        send_point(32'h0100_0000, 32'h0100_8000);
        send_point(32'hFF00_4000, 32'h00FF_C000);
        send_point(32'h0000_4A3D, 32'hFFFF_B5C3);
        send_point(32'h0000_0001, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h0000_0001);
        // reload two entries, then evaluate two points
        send_item(MODE_LOAD, 32'hFFFF_FFFF, 32'h0000_0000, 8'hFF, 8'hFF);
        send_item(MODE_LOAD, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 8'h00);
        send_point(32'h00FF_8000, 32'h00FF_8000);
        send_point(32'h0000_2000, 32'h0000_3000);
    endtask

    // mostly points, some table rewrites
    task automatic test_random_mix();
        logic [31:0] xv, yv;
        for (int n = 0; n < 1680; n++)
        begin
            no_idle = (n % 400) >= 320;
            if ($urandom_range(0, 99) < 12)
                send_item(MODE_LOAD, $urandom, $urandom, 8'($urandom), 8'($urandom));
            else
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        xv = $urandom;
                        yv = $urandom;
                    end
                    1:
                    begin
                        xv = 32'($signed(20'($urandom)));
                        yv = 32'($signed(20'($urandom)));
                    end
                    default:
                    begin
                        xv = 32'($signed(24'($urandom)));
                        yv = xv + 32'($signed(12'($urandom)));
                    end
                endcase
                send_point(xv, yv);
            end
        end
        no_idle = 1'b0;
    endtask

    // result check and output stall
    initial
    begin : result_checker
        int stall_left;
        logic signed [15:0] want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (noise_expected_q.size() == 0)
                begin
                    $display("%0t: noise item with none expected, actual %0d",
                             $time, noise);
                    failed = 1'b1;
                end
                else
                begin
                    want = noise_expected_q.pop_front();
                    if (noise !== want)
                    begin
                        $display("%0t: noise mismatch, expected %0d actual %0d",
                                 $time, want, noise);
                        failed = 1'b1;
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial
    begin
        failed      = 1'b0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_EVAL;
        x_coord     = '0;
        y_coord     = '0;
        table_index = '0;
        table_value = '0;
        out_stall   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_load();
        test_directed_points();
        test_random_mix();
        in_valid <= 1'b0;
        wait (noise_expected_q.size() == 0);
        repeat (40) @(posedge clk);
        if (!failed && noise_expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
